// File: sv/rps_pkg.sv
// ----------------------------------------------------------------------------
// Random permutation shuffle package
// Shared transaction types, generator constants and controller interface
// structs for the shuffle unit.
// ----------------------------------------------------------------------------
package rps_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned STEP_CNT_W = 5;
   localparam int unsigned ELEM_W = 8;

   localparam logic [WORD_W-1:0] SEED_A = 32'd123456789;
   localparam logic [WORD_W-1:0] SEED_B = 32'd362436069;
   localparam logic [WORD_W-1:0] SEED_C = 32'd521288629;
   localparam logic [WORD_W-1:0] SEED_D = 32'd88675123;
   localparam logic [WORD_W-1:0] SEED_E = 32'd5783321;
   localparam logic [WORD_W-1:0] SEED_WEYL = 32'd6615241;
   localparam logic [WORD_W-1:0] WEYL_STEP = 32'd362437;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SHUFFLE = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] element_res;
      logic              last;
      logic              empty_res;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic start;
      logic draw;
      logic read_pair;
      logic write_i;
      logic write_j;
      logic emit_read;
      logic emit_load;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic i_is_one;
      logic mod_busy;
      logic k_is_last;
      logic out_free;
   } status_type;

endpackage

// File: sv/rps_mod_unit.sv
// ----------------------------------------------------------------------------
// Random permutation shuffle modulo unit
// Restoring bit-serial remainder of a 32-bit draw by a small divisor, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module rps_mod_unit #(
   parameter int unsigned DIV_W = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rps_pkg::WORD_W-1:0]    dividend,
   input  logic [DIV_W-1:0]              divisor,
   output logic                          busy,
   output logic [DIV_W-1:0]              remainder
);

   logic                              busy_ff, busy_in;
   logic [rps_pkg::STEP_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [rps_pkg::WORD_W-1:0]        num_ff, num_in;
   logic [DIV_W-1:0]                  div_ff, div_in;
   logic [DIV_W-1:0]                  rem_ff, rem_in;
   logic [DIV_W:0]                    trial;
   logic [DIV_W:0]                    diff;

   always_comb begin
      trial = {rem_ff, num_ff[rps_pkg::WORD_W-1]};
      diff = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '1;
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[rps_pkg::WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIV_W-1:0];
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         cnt_in = cnt_ff - rps_pkg::STEP_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/rps_datapath.sv
// ----------------------------------------------------------------------------
// Random permutation shuffle datapath
// Element store, load count, xorwow generator, swap and emit indexes and the
// result register.
// ----------------------------------------------------------------------------
module rps_datapath #(
   parameter int unsigned MAX_ELEMENTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rps_pkg::cmd_type      cmd,
   output rps_pkg::status_type   status,
   input  logic [rps_pkg::ELEM_W-1:0] element,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rps_pkg::rsp_type      rsp_data
);

   localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
   localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [rps_pkg::ELEM_W-1:0] store [MAX_ELEMENTS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [rps_pkg::ELEM_W-1:0] rd_a_ff, rd_b_ff;

   logic [rps_pkg::WORD_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [rps_pkg::WORD_W-1:0] d_ff, d_in, e_ff, e_in, weyl_ff, weyl_in;
   logic [rps_pkg::WORD_W-1:0] t_mix, draw;

   logic                rsp_valid_ff, rsp_valid_in;
   rps_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic             full;
   logic             mod_busy;
   logic [CNT_W-1:0] rem;
   logic [CNT_W-1:0] divisor;
   logic [IDX_W-1:0] rd_addr_a;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [rps_pkg::ELEM_W-1:0] wr_data;

   rps_mod_unit #(
      .DIV_W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.draw),
      .dividend  (draw),
      .divisor   (divisor),
      .busy      (mod_busy),
      .remainder (rem)
   );

   // Generator step, with the draw taken from the advanced state.
   always_comb begin
      t_mix = a_ff ^ (a_ff >> 2);
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      weyl_in = weyl_ff;
      if (cmd.draw) begin
         a_in = b_ff;
         b_in = c_ff;
         c_in = d_ff;
         d_in = e_ff;
         e_in = (e_ff ^ (e_ff << 4)) ^ (t_mix ^ (t_mix << 1));
         weyl_in = weyl_ff + rps_pkg::WEYL_STEP;
      end
      draw = weyl_in + e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= rps_pkg::SEED_A;
         b_ff <= rps_pkg::SEED_B;
         c_ff <= rps_pkg::SEED_C;
         d_ff <= rps_pkg::SEED_D;
         e_ff <= rps_pkg::SEED_E;
         weyl_ff <= rps_pkg::SEED_WEYL;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
         weyl_ff <= weyl_in;
      end
   end

   assign full = (count_ff == CNT_W'(MAX_ELEMENTS));
   assign divisor = CNT_W'(i_ff) + CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (cmd.load && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         i_in = IDX_W'(count_ff - CNT_W'(1));
         k_in = '0;
      end
      if (cmd.read_pair) begin
         j_in = rem[IDX_W-1:0];
      end
      if (cmd.write_j) begin
         i_in = i_ff - IDX_W'(1);
      end
      if (cmd.emit_load) begin
         if (status.k_is_last) begin
            count_in = '0;
         end else begin
            k_in = k_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // Single write port shared by loads and the two halves of a swap.
   always_comb begin
      wr_en = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = element;
      if (cmd.load && !full) begin
         wr_en = 1'b1;
      end else if (cmd.write_i) begin
         wr_en = 1'b1;
         wr_addr = i_ff;
         wr_data = rd_b_ff;
      end else if (cmd.write_j) begin
         wr_en = 1'b1;
         wr_addr = j_ff;
         wr_data = rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   assign rd_addr_a = cmd.emit_read ? k_ff : i_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_pair || cmd.emit_read) begin
         rd_a_ff <= store[rd_addr_a];
      end
      if (cmd.read_pair) begin
         rd_b_ff <= store[rem[IDX_W-1:0]];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.element_res = rd_a_ff;
         rsp_data_in.last = status.k_is_last;
         rsp_data_in.empty_res = 1'b0;
      end else if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.element_res = '0;
         rsp_data_in.last = 1'b1;
         rsp_data_in.empty_res = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      status.count_zero = (count_ff == '0);
      status.count_one = (count_ff == CNT_W'(1));
      status.i_is_one = (i_ff == IDX_W'(1));
      status.mod_busy = mod_busy;
      status.k_is_last = (CNT_W'(k_ff) == (count_ff - CNT_W'(1)));
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// File: sv/rps_ctrl.sv
// ----------------------------------------------------------------------------
// Random permutation shuffle controller
// Sequences loads, the Fisher-Yates swap loop and the emission of results.
// ----------------------------------------------------------------------------
module rps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  rps_pkg::status_type  status,
   output rps_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DRAW = 3'd1;
   localparam logic [2:0] ST_MOD = 3'd2;
   localparam logic [2:0] ST_SWAP_A = 3'd3;
   localparam logic [2:0] ST_SWAP_B = 3'd4;
   localparam logic [2:0] ST_EMIT_READ = 3'd5;
   localparam logic [2:0] ST_EMIT_LOAD = 3'd6;
   localparam logic [2:0] ST_EMPTY = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == rps_pkg::MODE_SHUFFLE) begin
                  cmd.start = 1'b1;
                  if (status.count_zero) begin
                     state_in = ST_EMPTY;
                  end else if (status.count_one) begin
                     state_in = ST_EMIT_READ;
                  end else begin
                     state_in = ST_DRAW;
                  end
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_DRAW: begin
            cmd.draw = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (!status.mod_busy) begin
               cmd.read_pair = 1'b1;
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            cmd.write_i = 1'b1;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            cmd.write_j = 1'b1;
            state_in = status.i_is_one ? ST_EMIT_READ : ST_DRAW;
         end
         ST_EMIT_READ: begin
            cmd.emit_read = 1'b1;
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in = status.k_is_last ? ST_IDLE : ST_EMIT_READ;
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/random_permutation_shuffle_unit.sv
// ----------------------------------------------------------------------------
// Random permutation shuffle unit
// Loads byte elements, shuffles them with a xorwow-driven Fisher-Yates pass
// and emits them in index order.
// ----------------------------------------------------------------------------
// A load does not leave the idle state, so loads can be accepted every cycle
// while the unit is idle. A shuffle of n elements runs n - 1 swaps, each
// paced mostly by the bit-serial modulo unit that computes the swap index,
// then an emit read and an emit load step per element, the load waiting
// while the result side stalls. New transactions are accepted only once the
// previous shuffle has handed its last result to the output register.
module random_permutation_shuffle_unit #(
   parameter int unsigned MAX_ELEMENTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rps_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rps_pkg::rsp_type  rsp_data
);

   rps_pkg::cmd_type    cmd;
   rps_pkg::status_type status;

   rps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .status    (status),
      .cmd       (cmd)
   );

   rps_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .element   (req_data.element),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/rps_checker.sv
// ----------------------------------------------------------------------------
// Random permutation shuffle checker
// Port-level checks of the shuffle unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rps_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rps_pkg::rsp_type  rsp_data
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |-> rsp_data.last && (rsp_data.element_res == '0))
      else $error("empty result malformed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == rps_pkg::MODE_SHUFFLE) |=> req_stall)
      else $error("shuffle did not block new transactions");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == rps_pkg::MODE_LOAD) |=> !req_stall)
      else $error("load did not complete in one cycle");

endmodule

bind random_permutation_shuffle_unit rps_checker u_rps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
